@@ hdl/mchl_pkg.sv @@
package mchl_pkg;

   localparam int DEPTH   = 16;
   localparam int IDX_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int COLOR_W = 32;
   localparam int MODE_W  = 3;
   localparam int HS_W    = 5;

   localparam logic [HS_W-1:0] HS_RESET = HS_W'(16);

   typedef enum logic [MODE_W-1:0] {
      MODE_APPEND    = 3'd0,
      MODE_READ      = 3'd1,
      MODE_OVERWRITE = 3'd2,
      MODE_REMOVE    = 3'd3,
      MODE_CLEAR     = 3'd4
   } mode_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_SHIFT_RD,
      ST_SHIFT_WR,
      ST_FRONT_WR,
      ST_ROW_RD,
      ST_ROW_CMP,
      ST_PULL_RD,
      ST_PULL_WR,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic               we;
      logic [IDX_W-1:0]   waddr;
      logic [COLOR_W-1:0] wdata;
      logic [IDX_W-1:0]   raddr;
   } mem_req_type;

   typedef struct packed {
      logic [CNT_W-1:0]   entry_count;
      logic               changed;
      logic               valid_res;
      logic [COLOR_W-1:0] read_color;
   } rsp_type;

   function automatic logic [CNT_W-1:0] list_limit(input logic [HS_W-1:0] hs);
      logic [CNT_W-1:0] lim;
      if (hs == '0) begin
         lim = CNT_W'(1);
      end else if (32'(hs) > DEPTH) begin
         lim = CNT_W'(DEPTH);
      end else begin
         lim = CNT_W'(hs);
      end
      return lim;
   endfunction

endpackage

@@ hdl/mchl_store.sv @@
module mchl_store
   import mchl_pkg::*;
(
   input  logic               clock,
   input  mem_req_type        mem_req,
   output logic [COLOR_W-1:0] rd_data
);

   logic [COLOR_W-1:0] mem [DEPTH];
   logic [COLOR_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.we) begin
         mem[mem_req.waddr] <= mem_req.wdata;
      end
      rd_data_ff <= mem[mem_req.raddr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/mchl_ctrl.sv @@
module mchl_ctrl
   import mchl_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_fire,
   input  logic [MODE_W-1:0]  req_mode,
   input  logic [COLOR_W-1:0] req_color,
   input  logic [IDX_W-1:0]   req_row,
   input  logic [HS_W-1:0]    history_size,
   input  logic               rsp_free,
   input  logic [COLOR_W-1:0] rd_data,
   output logic               req_ready,
   output logic               rsp_load,
   output rsp_type            rsp,
   output mem_req_type        mem_req
);

   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic [MODE_W-1:0]  mode_ff, mode_in;
   logic [COLOR_W-1:0] color_ff, color_in;
   logic [IDX_W-1:0]   row_ff, row_in;
   logic [COLOR_W-1:0] rd_ff, rd_in;
   logic               valid_ff, valid_in;
   logic               chg_ff, chg_in;

   logic               hit;
   logic [CNT_W-1:0]   idx_next;
   logic [CNT_W-1:0]   keep;

   assign hit      = (rd_data == color_ff);
   assign idx_next = {1'b0, idx_ff} + CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      mode_ff  <= mode_in;
      color_ff <= color_in;
      row_ff   <= row_in;
      rd_ff    <= rd_in;
      valid_ff <= valid_in;
      chg_ff   <= chg_in;
   end

   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      mode_in   = mode_ff;
      color_in  = color_ff;
      row_in    = row_ff;
      rd_in     = rd_ff;
      valid_in  = valid_ff;
      chg_in    = chg_ff;
      req_ready = 1'b0;
      rsp_load  = 1'b0;
      keep      = count_ff;
      mem_req   = '{we: 1'b0, waddr: idx_ff, wdata: rd_data, raddr: idx_ff};

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_fire) begin
               mode_in  = req_mode;
               color_in = req_color;
               row_in   = req_row;
               rd_in    = '0;
               valid_in = 1'b0;
               chg_in   = 1'b0;
               idx_in   = '0;
               state_in = ST_DONE;
               case (req_mode)
                  MODE_APPEND: begin
                     valid_in = 1'b1;
                     if (count_ff == '0) begin
                        chg_in   = 1'b1;
                        count_in = CNT_W'(1);
                        state_in = ST_FRONT_WR;
                     end else begin
                        state_in = ST_SRCH_RD;
                     end
                  end
                  MODE_READ, MODE_OVERWRITE: begin
                     if ({1'b0, req_row} < count_ff) begin
                        state_in = ST_ROW_RD;
                     end
                  end
                  MODE_REMOVE: begin
                     if ({1'b0, req_row} < count_ff) begin
                        valid_in = 1'b1;
                        chg_in   = 1'b1;
                        idx_in   = req_row;
                        state_in = ST_PULL_RD;
                     end
                  end
                  MODE_CLEAR: begin
                     valid_in = 1'b1;
                     chg_in   = (count_ff != '0);
                     count_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SRCH_RD: begin
            state_in = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            if (hit) begin
               if (idx_ff == '0) begin
                  state_in = ST_DONE;
               end else begin
                  chg_in   = 1'b1;
                  state_in = ST_SHIFT_RD;
               end
            end else if (idx_next == count_ff) begin
               // not present: drop the oldest when at the limit, then insert
               if (count_ff >= list_limit(history_size)) begin
                  keep = count_ff - CNT_W'(1);
               end
               chg_in   = 1'b1;
               count_in = keep + CNT_W'(1);
               idx_in   = keep[IDX_W-1:0];
               state_in = (keep == '0) ? ST_FRONT_WR : ST_SHIFT_RD;
            end else begin
               idx_in   = idx_next[IDX_W-1:0];
               state_in = ST_SRCH_RD;
            end
         end
         ST_SHIFT_RD: begin
            mem_req.raddr = idx_ff - IDX_W'(1);
            state_in      = ST_SHIFT_WR;
         end
         ST_SHIFT_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff;
            mem_req.wdata = rd_data;
            idx_in        = idx_ff - IDX_W'(1);
            state_in      = (idx_ff == IDX_W'(1)) ? ST_FRONT_WR : ST_SHIFT_RD;
         end
         ST_FRONT_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = '0;
            mem_req.wdata = color_ff;
            state_in      = ST_DONE;
         end
         ST_ROW_RD: begin
            mem_req.raddr = row_ff;
            state_in      = ST_ROW_CMP;
         end
         ST_ROW_CMP: begin
            valid_in = 1'b1;
            if (mode_ff == MODE_READ) begin
               rd_in = rd_data;
            end else if (!hit) begin
               mem_req.we    = 1'b1;
               mem_req.waddr = row_ff;
               mem_req.wdata = color_ff;
               chg_in        = 1'b1;
            end
            state_in = ST_DONE;
         end
         ST_PULL_RD: begin
            mem_req.raddr = idx_next[IDX_W-1:0];
            if (idx_next >= count_ff) begin
               count_in = count_ff - CNT_W'(1);
               state_in = ST_DONE;
            end else begin
               state_in = ST_PULL_WR;
            end
         end
         ST_PULL_WR: begin
            mem_req.we    = 1'b1;
            mem_req.waddr = idx_ff;
            mem_req.wdata = rd_data;
            idx_in        = idx_next[IDX_W-1:0];
            state_in      = ST_PULL_RD;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp = '{entry_count: count_ff, changed: chg_ff, valid_res: valid_ff,
                  read_color: rd_ff};

endmodule

@@ hdl/mru_color_history_list_core.sv @@
// Channel  Direction  Beat fields
// req_     in         tuser: mode; tdata: color, row
// rsp_     out        tdata: read_color, valid_res, changed, entry_count
// csr_     in         data: history_size
//
// One item at a time; req_tready is high only while the sequencer is idle.
// Append searches from the front, then shifts the entries ahead of the match or
// end down one row and writes the color to row 0; read/overwrite use one row, remove
// pulls later entries forward; clear zeroes the count. There is one comparator.
// Reset empties the list and sets history_size to 16. The result register frees
// the sequencer as soon as rsp_tready takes the previous beat.
module mru_color_history_list_core
   import mchl_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // mode[2:0]
   input  logic [39:0] req_tdata,   // color[31:0], row[35:32], zero[39:36]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // read_color[31:0], valid_res[32], changed[33],
                                    // entry_count[38:34], zero[39]
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data
);

   logic [HS_W-1:0]    hs_ff;
   logic               rsp_valid_ff;
   rsp_type            rsp_ff;
   rsp_type            rsp_new;
   logic               rsp_load;
   logic               rsp_free;
   mem_req_type        mem_req;
   logic [COLOR_W-1:0] rd_data;
   logic               req_ready_int;

   assign csr_ready = 1'b1;
   assign rsp_free  = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hs_ff        <= HS_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            hs_ff <= csr_data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_ff <= rsp_new;
      end
   end

   mchl_ctrl u_ctrl (
      .clock        (clock),
      .reset        (reset),
      .req_fire     (req_tvalid && req_ready_int),
      .req_mode     (req_tuser),
      .req_color    (req_tdata[31:0]),
      .req_row      (req_tdata[35:32]),
      .history_size (hs_ff),
      .rsp_free     (rsp_free),
      .rd_data      (rd_data),
      .req_ready    (req_ready_int),
      .rsp_load     (rsp_load),
      .rsp          (rsp_new),
      .mem_req      (mem_req)
   );

   mchl_store u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   assign req_tready = req_ready_int;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {1'b0, rsp_ff};

endmodule

@@ tb/tb.sv @@
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import mchl_pkg::*;

   localparam int UNUSED_MODE_LO = 5;
   localparam int UNUSED_MODE_HI = 7;
   localparam int PALETTE_SIZE   = 20;

   class history_scoreboard;
      logic [COLOR_W-1:0] colors [DEPTH];
      int unsigned        fill;
      logic [HS_W-1:0]    history_size;
      rsp_type            due_results [$];
      int                 errors;

      function new();
         fill         = 0;
         history_size = HS_RESET;
         errors       = 0;
      endfunction

      function void set_history_size(logic [HS_W-1:0] hs);
         history_size = hs;
      endfunction

      function int unsigned keep_limit();
         if (history_size == 0) return 1;
         if (history_size > DEPTH) return DEPTH;
         return history_size;
      endfunction

      function void drop_row(int unsigned pos);
         for (int unsigned i = pos; i + 1 < fill; i++) colors[i] = colors[i+1];
         fill--;
      endfunction

      function void push_front(logic [COLOR_W-1:0] c);
         for (int unsigned i = fill; i > 0; i--) colors[i] = colors[i-1];
         colors[0] = c;
         fill++;
      endfunction

      function int unsigned pending();
         return due_results.size();
      endfunction

      // move-to-front list update for one accepted request beat
      function void note_request(logic [MODE_W-1:0] mode, logic [COLOR_W-1:0] c,
                                 logic [IDX_W-1:0] row);
         rsp_type r;
         int      pos;
         r   = '0;
         pos = -1;
         case (mode)
            MODE_APPEND: begin
               r.valid_res = 1'b1;
               for (int unsigned i = 0; i < fill; i++) begin
                  if (colors[i] == c) begin
                     pos = i;
                     break;
                  end
               end
               if (pos > 0) begin
                  drop_row(pos);
                  push_front(c);
                  r.changed = 1'b1;
               end else if (pos < 0) begin
                  if (fill >= keep_limit() && fill > 0) fill--;
                  push_front(c);
                  r.changed = 1'b1;
               end
            end
            MODE_READ: begin
               if (row < fill) begin
                  r.read_color = colors[row];
                  r.valid_res  = 1'b1;
               end
            end
            MODE_OVERWRITE: begin
               if (row < fill) begin
                  r.valid_res = 1'b1;
                  if (colors[row] != c) begin
                     colors[row] = c;
                     r.changed   = 1'b1;
                  end
               end
            end
            MODE_REMOVE: begin
               if (row < fill) begin
                  drop_row(row);
                  r.valid_res = 1'b1;
                  r.changed   = 1'b1;
               end
            end
            MODE_CLEAR: begin
               r.valid_res = 1'b1;
               r.changed   = (fill != 0);
               fill        = 0;
            end
            default: ;
         endcase
         r.entry_count = CNT_W'(fill);
         due_results.push_back(r);
      endfunction

      function void report(string field, logic [COLOR_W-1:0] want, logic [COLOR_W-1:0] got);
         errors++;
         $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      endfunction

      function void check_result(logic [39:0] beat);
         rsp_type got;
         rsp_type want;
         got = beat[$bits(rsp_type)-1:0];
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: unexpected result beat, expected none, got %h", $time, beat);
            return;
         end
         want = due_results.pop_front();
         if (got.read_color !== want.read_color)
            report("read_color", want.read_color, got.read_color);
         if (got.valid_res !== want.valid_res)
            report("valid_res", want.valid_res, got.valid_res);
         if (got.changed !== want.changed)
            report("changed", want.changed, got.changed);
         if (got.entry_count !== want.entry_count)
            report("entry_count", want.entry_count, got.entry_count);
      endfunction
   endclass

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [2:0]  req_tuser;   // mode[2:0]
   logic [39:0] req_tdata;   // color[31:0], row[35:32], zero[39:36]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // read_color[31:0], valid_res[32], changed[33],
                             // entry_count[38:34], zero[39]
   logic        csr_valid;
   logic        csr_ready;
   logic [4:0]  csr_data;

   history_scoreboard sb;
   logic [COLOR_W-1:0] palette [PALETTE_SIZE];
   int  burst_left;
   bit  hold_off_request;

   mru_color_history_list_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   initial begin
      #20_000_000;
      $display("tb: failure");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready)
            sb.note_request(req_tuser, req_tdata[31:0], req_tdata[35:32]);
         if (rsp_tvalid && rsp_tready)
            sb.check_result(rsp_tdata);
         if (csr_valid && csr_ready)
            sb.set_history_size(csr_data);
      end
   end

   // result side: random stall styles, plus one long hold-off on request
   initial begin
      int style;
      int period;
      int tick;
      style      = 0;
      period     = 2;
      tick       = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_off_request) begin
            hold_off_request = 1'b0;
            rsp_tready       = 1'b0;
            repeat (400) @(negedge clock);
         end
         tick++;
         if (tick % 64 == 0) begin
            style  = $urandom_range(0, 3);
            period = $urandom_range(2, 5);
         end
         case (style)
            0:       rsp_tready = 1'b1;
            1:       rsp_tready = 1'($urandom_range(0, 1));
            2:       rsp_tready = (tick % period == 0);
            default: rsp_tready = ($urandom_range(0, 7) != 0);
         endcase
      end
   end

   task automatic send_item(input logic [MODE_W-1:0] mode, input logic [COLOR_W-1:0] c,
                            input logic [IDX_W-1:0] row);
      if (burst_left <= 0) begin
         req_tvalid = 1'b0;
         repeat ($urandom_range(1, ($urandom_range(0, 3) == 0) ? 70 : 6)) @(negedge clock);
         burst_left = $urandom_range(1, 24);
      end
      req_tvalid = 1'b1;
      req_tuser  = mode;
      req_tdata  = {4'b0, row, c};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      @(negedge clock);
      burst_left--;
   endtask

   task automatic drain();
      req_tvalid = 1'b0;
      while (sb.pending() != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic write_history_size(input logic [HS_W-1:0] hs);
      csr_valid = 1'b1;
      csr_data  = hs;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   task automatic random_item();
      int                 sel;
      logic [MODE_W-1:0]  mode;
      logic [COLOR_W-1:0] c;
      logic [IDX_W-1:0]   row;
      sel = $urandom_range(0, 99);
      c   = ($urandom_range(0, 3) != 0) ? palette[$urandom_range(0, PALETTE_SIZE-1)]
                                         : $urandom();
      if (sb.fill > 0 && $urandom_range(0, 3) != 0) row = IDX_W'($urandom_range(0, sb.fill - 1));
      else row = IDX_W'($urandom_range(0, DEPTH - 1));
      if (sel < 45)      mode = MODE_APPEND;
      else if (sel < 60) mode = MODE_READ;
      else if (sel < 72) mode = MODE_OVERWRITE;
      else if (sel < 84) mode = MODE_REMOVE;
      else if (sel < 88) mode = MODE_CLEAR;
      else if (sel < 93) mode = MODE_W'($urandom_range(UNUSED_MODE_LO, UNUSED_MODE_HI));
      else               mode = MODE_W'($urandom());
      if (mode == MODE_OVERWRITE && row < sb.fill && $urandom_range(0, 2) == 0)
         c = sb.colors[row];
      send_item(mode, c, row);
   endtask

   initial begin
      int unsigned hs_plan [6];
      sb               = new();
      hold_off_request = 1'b0;
      burst_left       = 0;
      reset            = 1'b1;
      req_tvalid       = 1'b0;
      req_tuser        = '0;
      req_tdata        = '0;
      csr_valid        = 1'b0;
      csr_data         = '0;
      for (int i = 0; i < PALETTE_SIZE; i++) palette[i] = $urandom();
      palette[0] = '0;
      palette[1] = '1;
      hs_plan = '{31, 16, 1, 0, 7, 0};
      hs_plan[5] = $urandom_range(2, 15);

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty list, then small contents at the reset limit
      send_item(MODE_CLEAR, $urandom(), 0);
      send_item(MODE_READ, '0, 0);
      send_item(MODE_OVERWRITE, '1, 0);
      send_item(MODE_REMOVE, '0, '1);
      send_item(MODE_APPEND, '0, 0);
      send_item(MODE_APPEND, '1, 0);
      send_item(MODE_APPEND, '1, 0);
      send_item(MODE_APPEND, '0, 0);
      send_item(MODE_READ, '0, 1);
      send_item(MODE_READ, '0, '1);
      send_item(MODE_OVERWRITE, '1, 1);
      send_item(MODE_OVERWRITE, 32'hA5A5_5A5A, 0);
      for (int m = UNUSED_MODE_LO; m <= UNUSED_MODE_HI; m++)
         send_item(MODE_W'(m), $urandom(), IDX_W'($urandom()));
      send_item(MODE_REMOVE, '0, 1);
      send_item(MODE_REMOVE, '0, 0);
      drain();

      // oldest entry dropped at the limit
      write_history_size(2);
      send_item(MODE_APPEND, 32'h0000_0001, 0);
      send_item(MODE_APPEND, 32'h0000_0002, 0);
      send_item(MODE_APPEND, 32'h0000_0003, 0);
      send_item(MODE_APPEND, 32'h0000_0002, 0);
      send_item(MODE_CLEAR, '0, 0);
      send_item(MODE_CLEAR, '0, 0);
      drain();

      for (int p = 0; p < 6; p++) begin
         write_history_size(HS_W'(hs_plan[p]));
         for (int n = 0; n < 140; n++) begin
            if (p == 1 && n == 60) hold_off_request = 1'b1;
            random_item();
         end
         drain();
      end

      repeat (100) @(negedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

@@ sim.f @@
hdl/mchl_pkg.sv
hdl/mchl_store.sv
hdl/mchl_ctrl.sv
hdl/mru_color_history_list_core.sv
tb/tb.sv
